>>> rtl/core/wtsc_pkg.sv
// Shared types, codes and helper functions for the wave-table sound channel.
// No dependencies; every other file in rtl/core imports this package.
package wtsc_pkg;

  // Command codes as they arrive on in_cmd
  localparam logic [2:0] CMD_WR_REG  = 3'd0;
  localparam logic [2:0] CMD_RD_REG  = 3'd1;
  localparam logic [2:0] CMD_WR_WAVE = 3'd2;
  localparam logic [2:0] CMD_RD_WAVE = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;
  localparam logic [2:0] CMD_LEN     = 3'd5;

  // Channel register indexes
  localparam logic [2:0] REG_DAC  = 3'd0;
  localparam logic [2:0] REG_LEN  = 3'd1;
  localparam logic [2:0] REG_VOL  = 3'd2;
  localparam logic [2:0] REG_FLO  = 3'd3;
  localparam logic [2:0] REG_FHI  = 3'd4;
  localparam logic [2:0] REG_LAST = REG_FHI;

  // Read-back masks of unused bits
  localparam logic [7:0] RD_MASK_DAC = 8'h7F;
  localparam logic [7:0] RD_MASK_VOL = 8'h9F;
  localparam logic [7:0] RD_MASK_FHI = 8'hBF;
  localparam logic [7:0] RD_OPEN_BUS = 8'hFF;

  // Sizes
  localparam int DEF_MAX_TICK_CYCLES = 32;
  localparam int WAVE_BYTES  = 16;
  localparam int WAVE_AW     = $clog2(WAVE_BYTES);
  localparam int POS_W       = WAVE_AW + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int PERIOD_W    = 11;
  localparam int PERIOD_BASE = 2048;
  localparam int LEN_W       = 9;
  localparam int LEN_FULL    = 256;
  localparam int TIMER_W     = 14;
  localparam int T_W         = 16;

  // Operations after classification
  typedef enum logic [2:0] {
    OP_NOP,
    OP_WR_REG,
    OP_RD_REG,
    OP_WR_WAVE,
    OP_RD_WAVE,
    OP_TICK,
    OP_LEN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [2:0]         reg_idx;
    logic [WAVE_AW-1:0] wave_off;
    logic [7:0]         data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;
  } res_t;

  // Handshake and status between the back end and the top level
  typedef struct packed {
    logic cmd_pop;
    logic res_push;
    logic idle;
  } bk_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ,
    ST_OUT
  } bk_state_t;

  // Timer reload for a period code: (2048 - code) * 2
  function automatic logic [TIMER_W-1:0] reload_of(input logic [PERIOD_W-1:0] code);
    logic [PERIOD_W:0] diff;
    diff = (PERIOD_W + 1)'(PERIOD_BASE) - {1'b0, code};
    return TIMER_W'({diff, 1'b0});
  endfunction

  // Right shift applied to a nibble for each volume code
  function automatic logic [2:0] vol_shift(input logic [1:0] code);
    logic [2:0] s;
    case (code)
      2'd0:    s = 3'd4;
      2'd1:    s = 3'd0;
      2'd2:    s = 3'd1;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/wave_table_sound_channel_core.sv
// Wave-table sound channel: top level joining front end, queues and back end.
// Depends on wtsc_pkg, wtsc_front, wtsc_fifo and wtsc_back.
//
// Every request (register or wave RAM access, tick, length clock) yields one
// result carrying read data, the current sample level and the channel-on flag.
// A front end decodes requests into a two-entry command queue; a back-end
// sequencer executes one command at a time and writes a two-entry result
// queue. A command passes the sequencer states execute, wave RAM fetch and
// result (the result state holds while the result queue is full), and a tick
// adds timer checks in the position loop before the fetch.
// The single-step timer loop sets the tick rate. Wave RAM entries read as zero
// after reset through per-byte valid bits, so no clearing pass is needed.
module wave_table_sound_channel_core #(
  parameter int MAX_TICK_CYCLES = wtsc_pkg::DEF_MAX_TICK_CYCLES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_cmd,
  input  logic [2:0] in_reg_index,
  input  logic [3:0] in_wave_offset,
  input  logic [7:0] in_data,
  input  logic [5:0] in_cycles,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_read_data,
  output logic [3:0] out_sample,
  output logic       out_channel_on
);
  import wtsc_pkg::*;

  localparam int CW    = $clog2(MAX_TICK_CYCLES + 1);
  localparam int CMD_W = $bits(cmd_t) + CW;
  localparam int RES_W = $bits(res_t);

  logic             q_push, cmd_full, cmd_empty, res_full;
  logic [CMD_W-1:0] q_data, cmd_word;
  res_t             res, res_head;
  logic [RES_W-1:0] res_head_w;
  bk_ctl_t          bk_ctl;

  // Decode incoming requests
  wtsc_front #(
    .MAX_TICK_CYCLES (MAX_TICK_CYCLES),
    .CW              (CW)
  ) u_front (
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_reg_index   (in_reg_index),
    .in_wave_offset (in_wave_offset),
    .in_data        (in_data),
    .in_cycles      (in_cycles),
    .q_full         (cmd_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  // Hold decoded commands for the back end
  wtsc_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (cmd_full),
    .pop       (bk_ctl.cmd_pop),
    .pop_data  (cmd_word),
    .empty     (cmd_empty)
  );

  // Execute commands
  wtsc_back #(
    .CW (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_word),
    .res_full  (res_full),
    .res       (res),
    .ctl       (bk_ctl)
  );

  // Hold finished results until taken
  wtsc_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bk_ctl.res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head_w),
    .empty     (empty)
  );

  assign res_head       = res_t'(res_head_w);
  assign out_read_data  = res_head.read_data;
  assign out_sample     = res_head.sample;
  assign out_channel_on = res_head.channel_on;

  // A result is never pushed into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    bk_ctl.res_push |-> !res_full)
    else $error("result pushed into full queue");

  // An idle back end takes a waiting command at once
  a_back_takes_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_ctl.idle && !cmd_empty) |=> !bk_ctl.idle)
    else $error("back end stayed idle with a command waiting");

  // A nonzero sample only comes from an enabled channel
  a_sample_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_sample == 4'd0) || out_channel_on))
    else $error("sample nonzero while channel off");

endmodule

>>> rtl/core/wtsc_fifo.sv
// Small first-in first-out queue of flat words, used between the stages.
// Depends on wtsc_pkg for the default depth.
module wtsc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = wtsc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import wtsc_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == CNTW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/wtsc_front.sv
// Front end: accepts input requests, decodes and classifies them into commands.
// Depends on wtsc_pkg; feeds the command queue.
module wtsc_front #(
  parameter int MAX_TICK_CYCLES = wtsc_pkg::DEF_MAX_TICK_CYCLES,
  parameter int CW              = $clog2(MAX_TICK_CYCLES + 1)
) (
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            in_cmd,
  input  logic [2:0]            in_reg_index,
  input  logic [3:0]            in_wave_offset,
  input  logic [7:0]            in_data,
  input  logic [5:0]            in_cycles,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [$bits(wtsc_pkg::cmd_t)+CW-1:0] q_data
);
  import wtsc_pkg::*;

  cmd_t          cmd;
  logic [CW-1:0] cyc_sat;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Decode the command code; drop writes to registers that do not exist
  always_comb begin
    cmd.reg_idx  = in_reg_index;
    cmd.wave_off = in_wave_offset[WAVE_AW-1:0];
    cmd.data     = in_data;
    unique case (in_cmd)
      CMD_WR_REG:  cmd.op = (in_reg_index > REG_LAST) ? OP_NOP : OP_WR_REG;
      CMD_RD_REG:  cmd.op = OP_RD_REG;
      CMD_WR_WAVE: cmd.op = OP_WR_WAVE;
      CMD_RD_WAVE: cmd.op = OP_RD_WAVE;
      CMD_TICK:    cmd.op = OP_TICK;
      CMD_LEN:     cmd.op = OP_LEN;
      default:     cmd.op = OP_NOP;
    endcase
  end

  // Saturate the tick length at the configured bound
  assign cyc_sat = (int'(in_cycles) > MAX_TICK_CYCLES) ? CW'(MAX_TICK_CYCLES)
                                                       : CW'(in_cycles);

  assign q_data = {cmd, cyc_sat};

endmodule

>>> rtl/core/wtsc_back.sv
// Back end: sequencer that executes commands, holds channel state and wave RAM.
// Depends on wtsc_pkg; pops the command queue and pushes the result queue.
module wtsc_back #(
  parameter int CW = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_empty,
  input  logic [$bits(wtsc_pkg::cmd_t)+CW-1:0]  cmd_word,
  input  logic                                  res_full,
  output wtsc_pkg::res_t                        res,
  output wtsc_pkg::bk_ctl_t                     ctl
);
  import wtsc_pkg::*;

  cmd_t          c;
  logic [CW-1:0] cyc;

  bk_state_t state_r, state_nxt;
  logic                 dac_r, dac_nxt;
  logic                 chan_r, chan_nxt;
  logic [LEN_W-1:0]     len_left_r, len_left_nxt;
  logic [1:0]           vol_r, vol_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic                 len_act_r, len_act_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic signed [T_W-1:0] t_r, t_nxt;
  logic [7:0]           rd_r, rd_nxt;
  logic                 rd_wave_r, rd_wave_nxt;

  logic [7:0]         mem [WAVE_BYTES];
  logic [WAVE_BYTES-1:0] valid_r;
  logic [7:0]         mem_a_q, mem_b_q;
  logic               wr_en, rd_a_en, rd_b_en;
  logic               pop;

  logic [PERIOD_W-1:0]   period_new;
  logic signed [T_W-1:0] t_start;
  logic [3:0]            nib;

  assign c   = cmd_t'(cmd_word[$bits(cmd_t)+CW-1:CW]);
  assign cyc = cmd_word[CW-1:0];

  assign pop     = (state_r == ST_IDLE) && !cmd_empty;
  assign wr_en   = pop && (c.op == OP_WR_WAVE);
  assign rd_a_en = pop && (c.op == OP_RD_WAVE);
  assign rd_b_en = (state_r == ST_READ);

  assign period_new = {c.data[2:0], period_r[7:0]};
  assign t_start    = signed'({{(T_W - TIMER_W){1'b0}}, timer_r}) - signed'(T_W'(cyc));

  // Wave RAM storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[c.wave_off] <= c.data;
    end
  end

  // Registered reads; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      mem_a_q <= valid_r[c.wave_off] ? mem[c.wave_off] : '0;
    end
    if (rd_b_en) begin
      mem_b_q <= valid_r[pos_r[POS_W-1:1]] ? mem[pos_r[POS_W-1:1]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[c.wave_off] <= 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dac_r      <= 1'b0;
      chan_r     <= 1'b0;
      len_left_r <= '0;
      vol_r      <= '0;
      period_r   <= '0;
      len_act_r  <= 1'b0;
      timer_r    <= '0;
      pos_r      <= '0;
      rd_wave_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dac_r      <= dac_nxt;
      chan_r     <= chan_nxt;
      len_left_r <= len_left_nxt;
      vol_r      <= vol_nxt;
      period_r   <= period_nxt;
      len_act_r  <= len_act_nxt;
      timer_r    <= timer_nxt;
      pos_r      <= pos_nxt;
      rd_wave_r  <= rd_wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    rd_r <= rd_nxt;
  end

  // Next state and channel updates
  always_comb begin
    state_nxt    = state_r;
    dac_nxt      = dac_r;
    chan_nxt     = chan_r;
    len_left_nxt = len_left_r;
    vol_nxt      = vol_r;
    period_nxt   = period_r;
    len_act_nxt  = len_act_r;
    timer_nxt    = timer_r;
    pos_nxt      = pos_r;
    t_nxt        = t_r;
    rd_nxt       = rd_r;
    rd_wave_nxt  = rd_wave_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt   = ST_READ;
          rd_nxt      = '0;
          rd_wave_nxt = (c.op == OP_RD_WAVE);
          unique case (c.op)
            OP_WR_REG: begin
              unique case (c.reg_idx)
                REG_DAC: begin
                  dac_nxt = c.data[7];
                  if (!c.data[7]) begin
                    chan_nxt = 1'b0;
                  end
                end
                REG_LEN: len_left_nxt = LEN_W'(LEN_FULL) - {1'b0, c.data};
                REG_VOL: vol_nxt = c.data[6:5];
                REG_FLO: period_nxt = {period_r[PERIOD_W-1:8], c.data};
                REG_FHI: begin
                  len_act_nxt = c.data[6];
                  period_nxt  = period_new;
                  // Trigger restarts the channel when the DAC is on
                  if (c.data[7] && dac_r) begin
                    chan_nxt  = 1'b1;
                    timer_nxt = reload_of(period_new);
                    pos_nxt   = '0;
                    if (len_left_r == '0) begin
                      len_left_nxt = LEN_W'(LEN_FULL);
                    end
                  end
                end
                default: ;
              endcase
            end
            OP_RD_REG: begin
              unique case (c.reg_idx)
                REG_DAC: rd_nxt = RD_MASK_DAC | {dac_r, 7'd0};
                REG_VOL: rd_nxt = RD_MASK_VOL | {1'b0, vol_r, 5'd0};
                REG_FHI: rd_nxt = RD_MASK_FHI | {1'b0, len_act_r, 6'd0};
                default: rd_nxt = RD_OPEN_BUS;
              endcase
            end
            OP_TICK: begin
              if (chan_r) begin
                t_nxt     = t_start;
                state_nxt = ST_TICK;
              end
            end
            OP_LEN: begin
              if (len_act_r && (len_left_r != '0)) begin
                len_left_nxt = len_left_r - 1'b1;
                if (len_left_r == LEN_W'(1)) begin
                  chan_nxt = 1'b0;
                end
              end
            end
            OP_NOP, OP_WR_WAVE, OP_RD_WAVE: ;
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        // Step the position once per reload until the timer is positive
        if (t_r <= 0) begin
          t_nxt   = t_r + signed'(T_W'(reload_of(period_r)));
          pos_nxt = pos_r + 1'b1;
        end else begin
          timer_nxt = t_r[TIMER_W-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Form the result from the fetched wave byte
  assign nib = pos_r[0] ? mem_b_q[3:0] : mem_b_q[7:4];

  always_comb begin
    res.read_data  = rd_wave_r ? mem_a_q : rd_r;
    res.channel_on = chan_r;
    res.sample     = (chan_r && dac_r && (vol_r != '0)) ? (nib >> vol_shift(vol_r)) : '0;
  end

  assign ctl.cmd_pop  = pop;
  assign ctl.res_push = (state_r == ST_OUT) && !res_full;
  assign ctl.idle     = (state_r == ST_IDLE);

endmodule
